// ===== hdl/remote_command_packet_framer_assert.svh =====
// Assertion macros used by the remote command packet framer back end.
`ifndef REMOTE_COMMAND_PACKET_FRAMER_ASSERT_SVH
`define REMOTE_COMMAND_PACKET_FRAMER_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is high.
`define RCPF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RCPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rcpf_pkg.sv =====
// Types, constants and CRC function for the remote command packet framer.
package rcpf_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef logic [4:0]  byte_idx_type;
   typedef logic [15:0] crc_type;
   typedef logic [23:0] remote_id_type;

   // Packet byte positions
   localparam byte_idx_type IDX_LEAD_LAST = 5'd7;
   localparam byte_idx_type IDX_ID_HI     = 5'd8;
   localparam byte_idx_type IDX_ID_MID    = 5'd9;
   localparam byte_idx_type IDX_ID_LO     = 5'd10;
   localparam byte_idx_type IDX_SEP       = 5'd11;
   localparam byte_idx_type IDX_SEQ       = 5'd12;
   localparam byte_idx_type IDX_CMD_HI    = 5'd13;
   localparam byte_idx_type IDX_CMD_LO    = 5'd14;
   localparam byte_idx_type IDX_CRC_HI    = 5'd15;
   localparam byte_idx_type IDX_LAST      = 5'd16;

   localparam crc_type    CRC_INIT = 16'hFFFE;
   localparam crc_type    CRC_POLY = 16'h1021;
   localparam logic [7:0] SEP_BYTE = 8'hFF;

   typedef struct packed {
      logic [15:0] command_code;
      logic        use_override;
      logic [7:0]  override_sequence;
   } req_data_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } rsp_data_type;

   // One queued command, sequence already resolved
   typedef struct packed {
      logic [15:0] command_code;
      logic [7:0]  sequence_byte;
   } cmd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Fixed preamble byte at position idx (0..7)
   function automatic logic [7:0] lead_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0: val = 8'h53;
         3'd1: val = 8'h39;
         3'd2: val = 8'h14;
         3'd3: val = 8'hDD;
         3'd4: val = 8'h1C;
         3'd5: val = 8'h49;
         3'd6: val = 8'h34;
         3'd7: val = 8'h12;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // Fold one byte into the CRC, most significant bit first
   function automatic crc_type crc_byte(input crc_type crc, input logic [7:0] data);
      crc_type acc;
      acc = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== hdl/rcpf_front.sv =====
// Front end: accepts commands, resolves the sequence byte, holds remote id.
module rcpf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rcpf_pkg::req_data_type    req_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  rcpf_pkg::remote_id_type   csr_data,
   input  rcpf_pkg::queue_status_type q_status,
   output logic                      push,
   output rcpf_pkg::cmd_entry_type   push_entry,
   output rcpf_pkg::remote_id_type   remote_id
);
   import rcpf_pkg::*;

   logic [7:0]    seq_count_ff, seq_count_in;
   remote_id_type remote_id_ff, remote_id_in;

   assign req_ready = !q_status.full;
   assign csr_ready = 1'b1;
   assign push      = req_valid && req_ready;
   assign remote_id = remote_id_ff;

   // Pick the sequence byte for the accepted item
   always_comb begin
      push_entry.command_code  = req_data.command_code;
      push_entry.sequence_byte = req_data.use_override ? req_data.override_sequence
                                                       : seq_count_ff;
   end

   // Advance the counter only when it supplied the sequence
   always_comb begin
      seq_count_in = seq_count_ff;
      if (push && !req_data.use_override) begin
         seq_count_in = seq_count_ff + 8'd1;
      end
   end

   // Take a register write
   always_comb begin
      remote_id_in = remote_id_ff;
      if (csr_valid && csr_ready) begin
         remote_id_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_count_ff <= '0;
         remote_id_ff <= '0;
      end else begin
         seq_count_ff <= seq_count_in;
         remote_id_ff <= remote_id_in;
      end
   end

endmodule

// ===== hdl/rcpf_queue.sv =====
// Command queue between front and back ends.
module rcpf_queue #(
   parameter int unsigned DEPTH = rcpf_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rcpf_pkg::cmd_entry_type    push_entry,
   input  logic                       pop,
   output rcpf_pkg::cmd_entry_type    head_entry,
   output rcpf_pkg::queue_status_type status
);
   import rcpf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_entry_type    slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head_entry   = slots_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hdl/rcpf_back.sv =====
// Back end: serializes one queued command into a 17-byte packet with CRC.
module rcpf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rcpf_pkg::queue_status_type q_status,
   input  rcpf_pkg::cmd_entry_type    head_entry,
   input  rcpf_pkg::remote_id_type    remote_id,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rcpf_pkg::rsp_data_type     rsp_data
);
   import rcpf_pkg::*;
   `include "remote_command_packet_framer_assert.svh"

   byte_idx_type idx_ff, idx_in;
   crc_type      crc_ff, crc_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         advance;
   logic [7:0]   cur_byte;

   assign advance   = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign pop       = advance && (idx_ff == IDX_LAST);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Select the byte at the current position
   always_comb begin
      if (idx_ff <= IDX_LEAD_LAST) begin
         cur_byte = lead_byte(idx_ff[2:0]);
      end else begin
         unique case (idx_ff)
            IDX_ID_HI:  cur_byte = remote_id[23:16];
            IDX_ID_MID: cur_byte = remote_id[15:8];
            IDX_ID_LO:  cur_byte = remote_id[7:0];
            IDX_SEP:    cur_byte = SEP_BYTE;
            IDX_SEQ:    cur_byte = head_entry.sequence_byte;
            IDX_CMD_HI: cur_byte = head_entry.command_code[15:8];
            IDX_CMD_LO: cur_byte = head_entry.command_code[7:0];
            IDX_CRC_HI: cur_byte = crc_ff[15:8];
            IDX_LAST:   cur_byte = crc_ff[7:0];
            default:    cur_byte = 8'h00;
         endcase
      end
   end

   // Advance position, fold the byte into the CRC, load the output register
   always_comb begin
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.packet_byte = cur_byte;
         rsp_data_in.last_byte   = (idx_ff == IDX_LAST);
         if (idx_ff == IDX_LAST) begin
            idx_in = '0;
            crc_in = CRC_INIT;
         end else begin
            idx_in = idx_ff + 5'd1;
            if (idx_ff <= IDX_CMD_LO) begin
               crc_in = crc_byte(crc_ff, cur_byte);
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `RCPF_ASSERT(a_idx_range, clock, reset, (idx_ff <= IDX_LAST), "byte position out of range")
   `RCPF_ASSERT(a_head_held, clock, reset, (idx_ff != '0) |-> !q_status.empty, "head popped mid-packet")
   `RCPF_ASSERT(a_last_wraps, clock, reset, (rsp_valid_ff && rsp_data_ff.last_byte && $past(advance)) |-> (idx_ff == '0), "position not reset after last byte")

endmodule

// ===== hdl/remote_command_packet_framer.sv =====
// When the back end is idle, an accepted command item is first written into the queue,
// and its first packet byte is then loaded into the back end's output register.
// The back end sends one byte per cycle on the result channel while rsp_ready is high,
// 17 bytes per command; the queue keeps accepting commands meanwhile until it is full.
// Reset (synchronous, active high) clears the sequence counter, remote id,
// queue and output valid; the CRC restarts at 0xFFFE.
module remote_command_packet_framer #(
   parameter int unsigned QUEUE_DEPTH = rcpf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rcpf_pkg::req_data_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rcpf_pkg::rsp_data_type  rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  rcpf_pkg::remote_id_type csr_data
);
   import rcpf_pkg::*;

   queue_status_type q_status;
   cmd_entry_type    push_entry;
   cmd_entry_type    head_entry;
   remote_id_type    remote_id;
   logic             push;
   logic             pop;

   // Accept commands and resolve their sequence bytes
   rcpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry),
      .remote_id  (remote_id)
   );

   // Buffer resolved commands
   rcpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // Serialize packets
   rcpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_entry (head_entry),
      .remote_id  (remote_id),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
